// ===== rtl/core/lzgw_pkg.sv =====
// shared types, constants and phase codes for the gamma window decompressor
`timescale 1ns / 1ps
package lzgw_pkg;
	localparam int WindowDepth = 32768;
	localparam int PtrW = $clog2(WindowDepth);
	localparam int CntW = PtrW + 1;
	localparam int LenBits = 16;
	localparam logic [LenBits-1:0] LenMax = '1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_DONE = 3'd1;
	localparam logic [2:0] ST_BAD_OFFSET = 3'd2;
	localparam logic [2:0] ST_AFTER_END = 3'd3;
	localparam logic [2:0] ST_WRONG_CMD = 3'd4;
	localparam logic [2:0] ST_LEN_OVF = 3'd5;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [3:0] {
		PH_LIT_STOP = 4'd0,
		PH_LIT_DATA = 4'd1,
		PH_REP_STOP = 4'd2,
		PH_REP_DATA = 4'd3,
		PH_NEW_STOP = 4'd4,
		PH_NEW_DATA = 4'd5,
		PH_LIT_BYTES = 4'd6,
		PH_AFTER_LIT = 4'd7,
		PH_COPY = 4'd8,
		PH_AFTER_COPY = 4'd9,
		PH_OFF1 = 4'd10,
		PH_OFF2 = 4'd11
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_BITS,
		BK_READ,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic command;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic out_valid;
		logic need_byte;
		logic [2:0] status;
	} out_item_t;
endpackage

// ===== rtl/core/lzgw_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module lzgw_ram #(
	parameter int Width = 8,
	parameter int Depth = 32768
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/core/lzgw_front.sv =====
// input side: two entry queue holding accepted beats
`timescale 1ns / 1ps
module lzgw_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lzgw_pkg::in_item_t in_data,
	output logic q_valid,
	input logic q_take,
	output lzgw_pkg::in_item_t q_data
);
	lzgw_pkg::in_item_t buf_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic push;
	logic pop;

	assign in_stall = cnt_q == 2'd2;
	assign push = in_valid && !in_stall;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_take;
	assign q_data = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop) begin
				rd_q <= !rd_q;
			end
		end
	end

	// free slot sits behind the entries already held
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[rd_q ^ cnt_q[0]] <= in_data;
		end
	end
endmodule

// ===== rtl/core/lzgw_back.sv =====
// decode engine: control bits, literals, copies and window
`timescale 1ns / 1ps
module lzgw_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_take,
	input lzgw_pkg::in_item_t q_data,
	output logic out_valid,
	input logic out_stall,
	output lzgw_pkg::out_item_t out_data
);
	localparam int PW = lzgw_pkg::PtrW;
	localparam int CW = lzgw_pkg::CntW;
	localparam int LB = lzgw_pkg::LenBits;

	lzgw_pkg::back_state_t st_q, st_d;
	lzgw_pkg::phase_t ph_q, ph_d;
	logic [PW-1:0] wp_q, wp_d;
	logic [CW-1:0] prod_q, prod_d;
	logic [7:0] bb_q, bb_d, mask_q, mask_d;
	logic first_q, first_d;
	logic [LB-1:0] gam_q, gam_d, rem_q, rem_d;
	logic [PW-1:0] rep_q, rep_d;
	logic [7:0] ofb_q, ofb_d;
	logic fin_q, fin_d;
	logic [2:0] err_q, err_d;
	logic ov_q, ov_d;
	lzgw_pkg::out_item_t res_q, res_d;
	logic ram_we;
	logic [PW-1:0] ram_addr;
	logic [7:0] ram_wdata, ram_rdata;
	logic bit_ph, bit_v, rep_bad;
	logic signed [16:0] off2;
	logic [LB-1:0] rem_dec;

	lzgw_ram #(.Width(8), .Depth(lzgw_pkg::WindowDepth)) u_win (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign out_valid = ov_q;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lzgw_pkg::BK_IDLE;
			ph_q <= lzgw_pkg::PH_LIT_STOP;
			wp_q <= '0;
			prod_q <= '0;
			bb_q <= '0;
			mask_q <= '0;
			first_q <= 1'b0;
			gam_q <= LB'(1);
			rem_q <= '0;
			rep_q <= '0;
			ofb_q <= '0;
			fin_q <= 1'b0;
			err_q <= lzgw_pkg::ST_OK;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ph_q <= ph_d;
			wp_q <= wp_d;
			prod_q <= prod_d;
			bb_q <= bb_d;
			mask_q <= mask_d;
			first_q <= first_d;
			gam_q <= gam_d;
			rem_q <= rem_d;
			rep_q <= rep_d;
			ofb_q <= ofb_d;
			fin_q <= fin_d;
			err_q <= err_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	always_comb begin
		st_d = st_q;
		ph_d = ph_q;
		wp_d = wp_q;
		prod_d = prod_q;
		bb_d = bb_q;
		mask_d = mask_q;
		first_d = first_q;
		gam_d = gam_q;
		rem_d = rem_q;
		rep_d = rep_q;
		ofb_d = ofb_q;
		fin_d = fin_q;
		err_d = err_q;
		ov_d = ov_q && out_stall;
		res_d = res_q;
		q_take = 1'b0;
		ram_we = 1'b0;
		ram_addr = wp_q - rep_q;
		ram_wdata = q_data.in_byte;
		bit_v = 1'b0;
		rep_bad = (rep_q == '0) || ({1'b0, rep_q} > prod_q);
		off2 = 17'sd32512 - $signed({2'b0, q_data.in_byte & 8'd254, 7'd0})
			- $signed({9'b0, ofb_q & 8'd254}) - $signed({16'b0, q_data.in_byte[0]});
		rem_dec = (rem_q != '0) ? rem_q - LB'(1) : rem_q;
		bit_ph = (ph_q <= lzgw_pkg::PH_NEW_DATA) || (ph_q == lzgw_pkg::PH_AFTER_LIT)
			|| (ph_q == lzgw_pkg::PH_AFTER_COPY);
		unique case (st_q)
			lzgw_pkg::BK_IDLE: begin
				if (q_valid && !ov_d) begin
					res_d = '0;
					q_take = 1'b1;
					st_d = lzgw_pkg::BK_OUT;
					if (err_q != lzgw_pkg::ST_OK) begin
						res_d.status = err_q;
					end else if (fin_q) begin
						if (q_data.command == lzgw_pkg::CMD_BYTE) begin
							err_d = lzgw_pkg::ST_AFTER_END;
						end else begin
							res_d.status = lzgw_pkg::ST_WRONG_CMD;
						end
					end else if (q_data.command == lzgw_pkg::CMD_DRAIN) begin
						if (ph_q == lzgw_pkg::PH_COPY) begin
							st_d = lzgw_pkg::BK_READ;
						end else begin
							res_d.status = lzgw_pkg::ST_WRONG_CMD;
						end
					end else if (ph_q == lzgw_pkg::PH_COPY) begin
						res_d.status = lzgw_pkg::ST_WRONG_CMD;
					end else if (bit_ph) begin
						// fresh control byte, bit 7 is taken first
						bb_d = q_data.in_byte;
						mask_d = 8'd128;
						first_d = 1'b1;
						st_d = lzgw_pkg::BK_BITS;
					end else if (ph_q == lzgw_pkg::PH_LIT_BYTES) begin
						res_d.out_byte = q_data.in_byte;
						res_d.out_valid = 1'b1;
						ram_we = 1'b1;
						ram_addr = wp_q;
						wp_d = wp_q + PW'(1);
						if (prod_q < CW'(lzgw_pkg::WindowDepth)) begin
							prod_d = prod_q + CW'(1);
						end
						rem_d = rem_dec;
						if (rem_dec == '0) begin
							ph_d = lzgw_pkg::PH_AFTER_LIT;
						end
						st_d = lzgw_pkg::BK_BITS;
					end else if (ph_q == lzgw_pkg::PH_OFF1) begin
						ofb_d = q_data.in_byte;
						if (q_data.in_byte[0]) begin
							ph_d = lzgw_pkg::PH_OFF2;
						end else begin
							rep_d = PW'(8'd128 - {1'b0, q_data.in_byte[7:1]});
							gam_d = LB'(1);
							ph_d = lzgw_pkg::PH_NEW_STOP;
							st_d = lzgw_pkg::BK_BITS;
						end
					end else begin
						if (off2 <= 17'sd0) begin
							fin_d = 1'b1;
						end else begin
							rep_d = PW'(off2);
							gam_d = LB'(1);
							ph_d = lzgw_pkg::PH_NEW_STOP;
							st_d = lzgw_pkg::BK_BITS;
						end
					end
				end
			end
			lzgw_pkg::BK_READ: begin
				// window byte read at accept lands now, copy it to the head
				res_d.out_byte = ram_rdata;
				res_d.out_valid = 1'b1;
				ram_we = 1'b1;
				ram_addr = wp_q;
				ram_wdata = ram_rdata;
				wp_d = wp_q + PW'(1);
				if (prod_q < CW'(lzgw_pkg::WindowDepth)) begin
					prod_d = prod_q + CW'(1);
				end
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					ph_d = lzgw_pkg::PH_AFTER_COPY;
				end
				st_d = lzgw_pkg::BK_BITS;
			end
			lzgw_pkg::BK_BITS: begin
				// one control bit per cycle
				if (err_q == lzgw_pkg::ST_OK && !fin_q && bit_ph
						&& (mask_q > 8'd1 || first_q)) begin
					bit_v = |(bb_q & (first_q ? 8'd128 : mask_q >> 1));
					mask_d = first_q ? 8'd128 : mask_q >> 1;
					first_d = 1'b0;
					unique case (ph_q)
						lzgw_pkg::PH_LIT_STOP, lzgw_pkg::PH_REP_STOP,
						lzgw_pkg::PH_NEW_STOP: begin
							if (!bit_v) begin
								ph_d = lzgw_pkg::phase_t'(ph_q + 4'd1);
							end else if (ph_q == lzgw_pkg::PH_LIT_STOP) begin
								rem_d = gam_q;
								ph_d = lzgw_pkg::PH_LIT_BYTES;
							end else if (rep_bad) begin
								err_d = lzgw_pkg::ST_BAD_OFFSET;
							end else if (ph_q == lzgw_pkg::PH_REP_STOP) begin
								rem_d = gam_q;
								ph_d = lzgw_pkg::PH_COPY;
							end else if (gam_q == lzgw_pkg::LenMax) begin
								err_d = lzgw_pkg::ST_LEN_OVF;
							end else begin
								rem_d = gam_q + LB'(1);
								ph_d = lzgw_pkg::PH_COPY;
							end
						end
						lzgw_pkg::PH_AFTER_LIT, lzgw_pkg::PH_AFTER_COPY: begin
							if (bit_v) begin
								ph_d = lzgw_pkg::PH_OFF1;
							end else begin
								gam_d = LB'(1);
								ph_d = (ph_q == lzgw_pkg::PH_AFTER_LIT) ?
									lzgw_pkg::PH_REP_STOP : lzgw_pkg::PH_LIT_STOP;
							end
						end
						default: begin
							if (gam_q[LB-1]) begin
								err_d = lzgw_pkg::ST_LEN_OVF;
							end else begin
								gam_d = {gam_q[LB-2:0], bit_v};
								ph_d = lzgw_pkg::phase_t'(ph_q - 4'd1);
							end
						end
					endcase
				end else begin
					st_d = lzgw_pkg::BK_OUT;
				end
			end
			default: begin
				// BK_OUT: finalize status and need flag
				if (res_d.status == lzgw_pkg::ST_OK) begin
					if (err_q != lzgw_pkg::ST_OK) begin
						res_d.status = err_q;
					end else if (fin_q) begin
						res_d.status = lzgw_pkg::ST_DONE;
					end
				end
				if (err_q != lzgw_pkg::ST_OK && res_q.status == lzgw_pkg::ST_OK
						&& !res_q.out_valid) begin
					res_d.out_byte = '0;
				end
				res_d.need_byte = (err_q == lzgw_pkg::ST_OK) && !fin_q
					&& (ph_q != lzgw_pkg::PH_COPY);
				ov_d = 1'b1;
				st_d = lzgw_pkg::BK_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/core/lz_gamma_window_decompressor_core.sv =====
// top level of the gamma window decompressor
`timescale 1ns / 1ps
// Byte-serial LZ decompressor with interlaced gamma lengths. Each input beat
// is either a compressed byte (command 0) or a drain tick (command 1) and
// yields exactly one result beat. A two-entry input queue decouples the
// upstream side from the decode engine. The result register holds a beat
// until downstream takes it, and the engine takes no new beat from the queue
// while a result waits. Each beat is queued, then taken in BK_IDLE. A beat
// that is rejected, meets a latched error, ends the stream or is the first
// of two offset bytes goes to BK_OUT, which registers its result. Any other
// compressed byte first decodes the control bits after it in BK_BITS (up to
// 8 per control byte); a drain reads the window in BK_READ before that.
// The 32 KiB history window is a single port ram with registered read and
// needs no clearing pass after reset.
module lz_gamma_window_decompressor_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lzgw_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output lzgw_pkg::out_item_t out_data
);
	logic q_valid;
	logic q_take;
	lzgw_pkg::in_item_t q_data;

	// front: accepts beats into a short queue
	lzgw_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
	);

	// back: decodes bits, writes and reads the window, registers the result
	lzgw_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_data(q_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);
endmodule
